// ===== hw/rtl/tasp_pkg.sv =====
// ----------------------------------------------------------------------------
// tasp_pkg
// Shared types and constants of the tar archive stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tasp_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int PATH_LIMIT  = 4096;
  localparam int NAME_LIMIT  = 98;

  localparam int SIZE_OFF    = 124;
  localparam int SIZE_DIGITS = 11;
  localparam int TYPE_OFF    = 156;
  localparam int MAGIC_OFF   = 257;
  localparam int MAGIC_LEN   = 5;
  localparam int LAST_OFF    = BLOCK_BYTES - 1;

  localparam int OFF_W    = $clog2(BLOCK_BYTES);
  localparam int SIZE_W   = 33;
  localparam int CNT_W    = 7;
  localparam int PREFIX_W = 12;
  // wide enough for prefix plus name length and for the limit itself
  localparam int PATH_W   = $clog2(PATH_LIMIT + (1 << PREFIX_W) + (1 << CNT_W)) + 1;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNC,
    ST_BAD_SIZE,
    ST_NAME_LONG,
    ST_PATH_LIMIT
  } status_t;

  typedef enum logic {
    KIND_ENTRY,
    KIND_FINISH
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [7:0]         entry_type;
    logic               is_directory;
    logic [SIZE_W-1:0]  file_size;
    logic [CNT_W-1:0]   name_length;
    logic               last_of_run;
  } res_t;

  // up to two results come out of one byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tasp_parser.sv =====
// ----------------------------------------------------------------------------
// tasp_parser
// Per-byte header/data/padding walker; emits up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tasp_parser
  import tasp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [PREFIX_W-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_fin,
  output push_t                    push
);

  phase_t              phase_r, phase_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt, off_inc;
  logic [PREFIX_W-1:0] prefix_r;
  logic [SIZE_W-1:0]   acc_r, acc_h;
  logic                bad_r, bad_h;
  logic                magic_r, magic_h;
  logic [7:0]          type_r, type_h;
  logic                dot_r, dot_h;
  logic [CNT_W-1:0]    cnt_r, cnt_h;
  logic                ended_r, ended_h;
  logic                slash_r, slash_h;
  logic [SIZE_W-1:0]   rem_r, rem_nxt, rem_dec;

  logic                prefix_over;
  logic                hdr_use;
  logic [CNT_W-1:0]    conc_cnt, conc_len;
  logic                conc_slash;
  logic [7:0]          conc_type;
  logic [SIZE_W-1:0]   conc_size;
  logic                conc_long, conc_path, conc_fail;
  status_t             conc_st;
  logic                do_desc, do_fin;
  status_t             fin_st;
  res_t                desc_res, fin_res;

  assign prefix_over = PATH_W'(prefix_r) >= PATH_W'(PATH_LIMIT);
  assign hdr_use = in_valid && (phase_r == PH_HEADER) && !((off_r == '0) && prefix_over);
  assign off_inc = off_r + OFF_W'(1);
  assign rem_dec = rem_r - SIZE_W'(rem_r != '0);

  // header field capture, applied to the state as of this byte
  always_comb begin
    acc_h   = acc_r;
    bad_h   = bad_r;
    magic_h = magic_r;
    type_h  = type_r;
    dot_h   = dot_r;
    cnt_h   = cnt_r;
    ended_h = ended_r;
    slash_h = slash_r;
    if (off_r == '0) begin
      acc_h   = '0;
      bad_h   = 1'b0;
      magic_h = 1'b1;
      type_h  = '0;
      dot_h   = (in_byte == CH_DOT);
      cnt_h   = '0;
      ended_h = 1'b0;
      slash_h = 1'b0;
    end
    if ((off_r == OFF_W'(1)) && dot_r && (in_byte == CH_SLASH)) begin
      // leading "./" restarts the name
      cnt_h   = '0;
      ended_h = 1'b0;
      slash_h = 1'b0;
    end else if (!ended_h && (cnt_h < CNT_W'(NAME_LIMIT))) begin
      if (in_byte == CH_NUL) begin
        ended_h = 1'b1;
      end else begin
        cnt_h   = cnt_h + CNT_W'(1);
        slash_h = (in_byte == CH_SLASH);
      end
    end
    if ((off_r >= OFF_W'(SIZE_OFF)) && (off_r < OFF_W'(SIZE_OFF + SIZE_DIGITS))) begin
      if ((in_byte < CH_ZERO) || (in_byte > CH_SEVEN)) begin
        bad_h = 1'b1;
      end else begin
        acc_h = {acc_h[SIZE_W-4:0], in_byte[2:0]};
      end
    end
    if (off_r == OFF_W'(TYPE_OFF)) begin
      type_h = in_byte;
    end
    if ((off_r >= OFF_W'(MAGIC_OFF)) && (off_r < OFF_W'(MAGIC_OFF + MAGIC_LEN))) begin
      if (in_byte != magic_char(3'(off_r - OFF_W'(MAGIC_OFF)))) begin
        magic_h = 1'b0;
      end
    end
  end

  // entry conclusion: name checks and descriptor fields
  always_comb begin
    if (phase_r == PH_HEADER) begin
      conc_cnt   = cnt_h;
      conc_slash = slash_h;
      conc_type  = type_h;
      conc_size  = acc_h;
    end else begin
      conc_cnt   = cnt_r;
      conc_slash = slash_r;
      conc_type  = type_r;
      conc_size  = acc_r;
    end
  end

  assign conc_len  = conc_cnt - CNT_W'((conc_cnt != '0) && conc_slash);
  assign conc_long = conc_cnt >= CNT_W'(NAME_LIMIT);
  assign conc_path = (PATH_W'(prefix_r) + PATH_W'(conc_len)) >= PATH_W'(PATH_LIMIT);
  assign conc_fail = conc_long || conc_path;
  assign conc_st   = conc_long ? ST_NAME_LONG : ST_PATH_LIMIT;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    do_desc   = 1'b0;
    do_fin    = 1'b0;
    fin_st    = ST_OK;
    if (in_valid) begin
      unique case (phase_r)
        PH_HEADER: begin
          if ((off_r == '0) && prefix_over) begin
            do_fin = 1'b1;
            fin_st = ST_PATH_LIMIT;
          end else if (off_r != OFF_W'(LAST_OFF)) begin
            if (in_fin) begin
              do_fin = 1'b1;
              fin_st = ST_TRUNC;
            end else begin
              off_nxt = off_inc;
            end
          end else if (!magic_h) begin
            do_fin = 1'b1;
            fin_st = ST_OK;
          end else if (bad_h) begin
            do_fin = 1'b1;
            fin_st = ST_BAD_SIZE;
          end else if (acc_h == '0) begin
            off_nxt = '0;
            if (conc_fail) begin
              do_fin = 1'b1;
              fin_st = conc_st;
            end else begin
              do_desc = 1'b1;
              do_fin  = in_fin;
            end
          end else if (in_fin) begin
            do_fin = 1'b1;
            fin_st = ST_TRUNC;
          end else begin
            phase_nxt = PH_DATA;
            off_nxt   = '0;
          end
        end
        PH_DATA: begin
          off_nxt = off_inc;
          if (rem_dec != '0) begin
            if (in_fin) begin
              do_fin = 1'b1;
              fin_st = ST_TRUNC;
            end
          end else if (conc_fail) begin
            do_fin = 1'b1;
            fin_st = conc_st;
          end else begin
            do_desc = 1'b1;
            if (in_fin) begin
              do_fin = 1'b1;
            end else begin
              phase_nxt = (off_inc == '0) ? PH_HEADER : PH_PAD;
            end
          end
        end
        PH_PAD: begin
          off_nxt = off_inc;
          if (in_fin) begin
            do_fin = 1'b1;
          end else if (off_inc == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_DONE: begin
          if (in_fin) begin
            phase_nxt = PH_HEADER;
            off_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          off_nxt   = '0;
        end
      endcase
      if (do_fin) begin
        phase_nxt = in_fin ? PH_HEADER : PH_DONE;
        off_nxt   = '0;
      end
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    if (in_valid && (phase_r == PH_HEADER) && (phase_nxt == PH_DATA)) begin
      rem_nxt = acc_h;
    end else if (in_valid && (phase_r == PH_DATA)) begin
      rem_nxt = rem_dec;
    end
  end

  // outputs
  always_comb begin
    desc_res.kind         = KIND_ENTRY;
    desc_res.status       = ST_OK;
    desc_res.entry_type   = conc_type;
    desc_res.is_directory = (conc_type == CH_FIVE);
    desc_res.file_size    = conc_size;
    desc_res.name_length  = conc_len;
    desc_res.last_of_run  = !do_fin;

    fin_res.kind         = KIND_FINISH;
    fin_res.status       = fin_st;
    fin_res.entry_type   = '0;
    fin_res.is_directory = 1'b0;
    fin_res.file_size    = '0;
    fin_res.name_length  = '0;
    fin_res.last_of_run  = 1'b1;

    push.cnt = 2'(do_desc) + 2'(do_fin);
    push.r0  = do_desc ? desc_res : fin_res;
    push.r1  = fin_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      prefix_r <= '0;
      acc_r    <= '0;
      bad_r    <= 1'b0;
      magic_r  <= 1'b1;
      type_r   <= '0;
      dot_r    <= 1'b0;
      cnt_r    <= '0;
      ended_r  <= 1'b0;
      slash_r  <= 1'b0;
      rem_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      rem_r   <= rem_nxt;
      if (cfg_wr_en) begin
        prefix_r <= cfg_wr_data;
      end
      if (hdr_use) begin
        acc_r   <= acc_h;
        bad_r   <= bad_h;
        magic_r <= magic_h;
        type_r  <= type_h;
        dot_r   <= dot_h;
        cnt_r   <= cnt_h;
        ended_r <= ended_h;
        slash_r <= slash_h;
      end
    end
  end

  a_data_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (rem_r != '0))
    else $error("data phase with nothing left to consume");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.r0.kind == KIND_ENTRY) && (push.r1.kind == KIND_FINISH)
                           && in_fin)
    else $error("two results from one byte must be descriptor then finish");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid |-> (push.cnt == 2'd0) && (phase_nxt == phase_r))
    else $error("parser moved without a byte");

  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NAME_LIMIT))
    else $error("name count beyond limit");

endmodule

`default_nettype wire

// ===== hw/rtl/tasp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// tasp_result_fifo
// Small result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module tasp_result_fifo
  import tasp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  res_t              mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign room      = count_r <= FCNT_W'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign wr_ptr_nxt = wr_ptr_r + FPTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + FPTR_W'(pop);
  assign count_nxt  = count_r + FCNT_W'(push.cnt) - FCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + FPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (count_r + FCNT_W'(push.cnt) <= FCNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != FCNT_W'(FIFO_DEPTH)) |->
      (FPTR_W'(wr_ptr_r - rd_ptr_r) == FPTR_W'(count_r)))
    else $error("queue pointers disagree with fill count");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (push.cnt == 2'd0)) |=> (count_r == $past(count_r) - FCNT_W'(1)))
    else $error("pop did not drain one entry");

endmodule

`default_nettype wire

// ===== hw/rtl/tar_archive_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tar_archive_stream_parser
// Streaming ustar archive walker: one archive byte in, entry descriptors and
// archive-finished results out.
// ----------------------------------------------------------------------------
// Takes one archive byte per clock cycle while in_tready is high. Each byte
// is held in an input register, walked through the header/data/padding
// logic combinationally, and any results go into a four-entry result queue,
// so both the input register and the queue lie between a byte and its result.
// Most bytes produce no result; a byte that ends an entry and the archive at
// once produces two (descriptor then finish), which the queue drains one per
// cycle while the output is taken. The input side stalls only while the
// queue holds fewer than two free entries, so the sustained rate is one byte
// per cycle whenever the output is taken. prefix_length is to be written
// via cfg_wr_en/cfg_wr_data between archives; the block does not enforce it.
`default_nettype none

module tar_archive_stream_parser
  import tasp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [PREFIX_W-1:0] cfg_wr_data,   // prefix_length
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,      // [7:0] data_byte
  input  wire logic                in_tlast,      // final_byte
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [2:0] status, [10:3] entry_type, [11] is_directory, [44:12] file_size,
  // [51:45] name_length, [55:52] zero
  output logic [55:0]              out_tdata,
  output logic                     out_tuser,     // kind
  output logic                     out_tlast      // last_of_run
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_fin_r;
  logic       room;
  logic       advance;
  push_t      push;
  res_t       out_res;

  assign advance   = in_v_r && room;
  assign in_tready = !in_v_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_fin_r  <= in_tlast;
    end
  end

  tasp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (advance),
    .in_byte     (in_byte_r),
    .in_fin      (in_fin_r),
    .push        (push)
  );

  tasp_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0000, out_res.name_length, out_res.file_size,
                      out_res.is_directory, out_res.entry_type, out_res.status};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last_of_run;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !room) |=> (in_v_r && $stable(in_byte_r) && $stable(in_fin_r)))
    else $error("held byte lost while queue was full");

  a_push_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> advance)
    else $error("result produced without a byte");

  a_finish_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_res.kind == KIND_FINISH)) |-> out_res.last_of_run)
    else $error("finish result not marked last");

endmodule

`default_nettype wire
